### rtl/frps_pkg.sv
// Package for the frame record/playback sequencer: field widths, command and
// mode codes, and the item and result records.
// Depends on nothing; frps_core and the top level refer to it by scoped names.
package frps_pkg;

	localparam int CH_NUM     = 5;
	localparam int VAL_W      = 16;
	localparam int OP_W       = 3;
	localparam int MODE_W     = 2;
	localparam int POS_OUT_W  = 12;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 112;

	typedef enum logic [OP_W-1:0] {
		OP_TICK      = 3'd0,
		OP_REC_START = 3'd1,
		OP_REC_STOP  = 3'd2,
		OP_PLAY      = 3'd3,
		OP_LOOP      = 3'd4
	} op_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_BYPASS   = 2'd0,
		MODE_RECORD   = 2'd1,
		MODE_PLAYBACK = 2'd2
	} mode_t;

	typedef logic [CH_NUM-1:0][VAL_W-1:0] vals_t;

	typedef struct packed {
		op_t   op;
		vals_t vals;
	} item_t;

	typedef struct packed {
		logic                 playback_done;
		logic                 store_full;
		logic [POS_OUT_W-1:0] recorded_length;
		logic [POS_OUT_W-1:0] position;
		mode_t                mode_now;
		vals_t                vals;
	} result_t;

endpackage

### rtl/frps_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module frps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/frps_core.sv
// Sequencer state (mode, position, length, loop) and the per-item update.
// Depends on frps_pkg; drives the write side and read address of the frame RAM.
module frps_core #(
	parameter int FRAME_DEPTH = 2048,
	localparam int POS_W = $clog2(FRAME_DEPTH + 1),
	localparam int AW = $clog2(FRAME_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              commit,
	input  frps_pkg::item_t   item,
	input  frps_pkg::vals_t   rd_data,
	output frps_pkg::result_t result,
	output logic              wr_en,
	output logic [AW-1:0]     wr_addr,
	output frps_pkg::vals_t   wr_data,
	output logic [AW-1:0]     rd_addr
);

	frps_pkg::mode_t  mode_q, mode_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [POS_W-1:0] len_q, len_d;
	logic             loop_q, loop_d;
	logic [POS_W-1:0] pos_inc;
	logic [POS_W-1:0] rd_pos;
	logic             store_write;
	frps_pkg::vals_t  vals;
	logic             full;
	logic             done;
	logic [POS_W+frps_pkg::POS_OUT_W-1:0] pos_ext;
	logic [POS_W+frps_pkg::POS_OUT_W-1:0] len_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= frps_pkg::MODE_BYPASS;
			pos_q  <= '0;
			len_q  <= '0;
			loop_q <= 1'b0;
		end else if (commit) begin
			mode_q <= mode_d;
			pos_q  <= pos_d;
			len_q  <= len_d;
			loop_q <= loop_d;
		end
	end

	assign pos_inc = pos_q + POS_W'(1);

	always_comb begin
		mode_d      = mode_q;
		pos_d       = pos_q;
		len_d       = len_q;
		loop_d      = loop_q;
		vals        = '0;
		full        = 1'b0;
		done        = 1'b0;
		store_write = 1'b0;
		unique case (item.op)
			frps_pkg::OP_TICK: begin
				if (mode_q == frps_pkg::MODE_PLAYBACK) begin
					if ((len_q == '0) || (pos_q >= len_q) ||
						(pos_q >= POS_W'(FRAME_DEPTH))) begin
						// Nothing left to replay: fall back to pass-through.
						mode_d = frps_pkg::MODE_BYPASS;
						done   = 1'b1;
						vals   = item.vals;
					end else begin
						vals  = rd_data;
						pos_d = pos_inc;
						if (pos_inc >= len_q) begin
							if (loop_q) begin
								pos_d = '0;
							end else begin
								mode_d = frps_pkg::MODE_BYPASS;
								done   = 1'b1;
							end
						end
					end
				end else begin
					vals = item.vals;
					if (mode_q == frps_pkg::MODE_RECORD) begin
						if (pos_q < POS_W'(FRAME_DEPTH)) begin
							store_write = 1'b1;
							pos_d       = pos_inc;
						end
						if (pos_d >= POS_W'(FRAME_DEPTH)) begin
							mode_d = frps_pkg::MODE_BYPASS;
							len_d  = pos_d;
							full   = 1'b1;
						end
					end
				end
			end
			frps_pkg::OP_REC_START: begin
				pos_d  = '0;
				mode_d = frps_pkg::MODE_RECORD;
			end
			frps_pkg::OP_REC_STOP: begin
				mode_d = frps_pkg::MODE_BYPASS;
				len_d  = pos_q;
			end
			frps_pkg::OP_PLAY: begin
				// A recording in progress is closed first, keeping its length.
				if (mode_q == frps_pkg::MODE_RECORD) begin
					len_d = pos_q;
				end
				loop_d = 1'b0;
				pos_d  = '0;
				mode_d = frps_pkg::MODE_PLAYBACK;
			end
			frps_pkg::OP_LOOP: begin
				loop_d = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign wr_en   = commit && store_write;
	assign wr_addr = pos_q[AW-1:0];
	assign wr_data = item.vals;

	// The RAM always looks up the frame at the position the next item will see,
	// so its registered output is ready when that item is processed.
	assign rd_pos  = commit ? pos_d : pos_q;
	assign rd_addr = (rd_pos >= POS_W'(FRAME_DEPTH)) ? '0 : rd_pos[AW-1:0];

	assign pos_ext = {{frps_pkg::POS_OUT_W{1'b0}}, pos_d};
	assign len_ext = {{frps_pkg::POS_OUT_W{1'b0}}, len_d};

	always_comb begin
		result.vals            = vals;
		result.mode_now        = mode_d;
		result.position        = pos_ext[frps_pkg::POS_OUT_W-1:0];
		result.recorded_length = len_ext[frps_pkg::POS_OUT_W-1:0];
		result.store_full      = full;
		result.playback_done   = done;
	end

endmodule

### rtl/frame_record_playback_sequencer_unit.sv
// Top level of the frame record/playback sequencer: input register, sequencer
// core, frame RAM and output register.
// Depends on frps_pkg, frps_ram and frps_core.
//
//   Channel  | Signals                          | Carries
//   ---------+----------------------------------+------------------------------
//   input    | s_tvalid s_tready s_tdata s_tuser | one tick or command request
//   output   | m_tvalid m_tready m_tdata         | one result per input request
//
// One request is accepted per cycle while the input register is empty or its
// request moves on. A request waits in the input register, where the core
// updates the state and the frame RAM is read or written, and its result then
// moves into the output register. The RAM lookup for the next request is
// issued in the same cycle as that update, so replay runs without gaps. Reset
// clears the state to bypass at position zero; the frame RAM is not cleared. A
// stalled output holds its result while one more request waits in the input register.
module frame_record_playback_sequencer_unit #(
	parameter int FRAME_DEPTH = 2048
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// in_ch0, in_ch1, in_ch2, in_ch3, in_ch4
	input  logic [frps_pkg::IN_DATA_W-1:0]     s_tdata,
	// op
	input  logic [frps_pkg::OP_W-1:0]          s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// out_ch0..out_ch4, mode_now, position, recorded_length, store_full,
	// playback_done, zero fill
	output logic [frps_pkg::OUT_DATA_W-1:0]    m_tdata
);

	localparam int AW = $clog2(FRAME_DEPTH);

	logic              valid_s1;
	frps_pkg::item_t   item_s1;
	logic              advance;
	logic              m_tvalid_q;
	frps_pkg::result_t res_q;
	frps_pkg::result_t result;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	frps_pkg::vals_t   wr_data;
	logic [AW-1:0]     rd_addr;
	frps_pkg::vals_t   rd_data;

	assign advance  = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.op   <= frps_pkg::op_t'(s_tuser);
			item_s1.vals <= frps_pkg::vals_t'(s_tdata);
		end
	end

	frps_core #(
		.FRAME_DEPTH(FRAME_DEPTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.commit  (advance),
		.item    (item_s1),
		.rd_data (rd_data),
		.result  (result),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr)
	);

	frps_ram #(
		.WIDTH(frps_pkg::CH_NUM * frps_pkg::VAL_W),
		.DEPTH(FRAME_DEPTH)
	) u_frames (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, res_q};

endmodule
